// ===== rtl/core/ccse_pkg.sv =====
package ccse_pkg;

    localparam int BYTES_PER_WORD = 8;
    localparam int DATA_W         = 64;
    localparam int COUNT_W        = 4;
    localparam int CRC_W          = 32;
    localparam int QUEUE_DEPTH    = 2;
    localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB88320;
    localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFFFFFF;

    typedef struct packed {
        logic [DATA_W-1:0]  data_word;
        logic [COUNT_W-1:0] byte_count;
        logic               first_word;
        logic               last_word;
        logic [CRC_W-1:0]   seed_crc;
    } t_item;

    function automatic logic [CRC_W-1:0] crc_tab(input logic [7:0] idx);
        logic [CRC_W-1:0] c;
        c = {24'd0, idx};
        for (int b = 0; b < 8; b++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [7:0]       byte_val);
        return (crc >> 8) ^ crc_tab(crc[7:0] ^ byte_val);
    endfunction

    function automatic logic [CRC_W-1:0] crc_word(input logic [CRC_W-1:0]   crc,
                                                  input logic [DATA_W-1:0]  data,
                                                  input logic [COUNT_W-1:0] count);
        logic [CRC_W-1:0] c;
        c = crc;
        for (int i = 0; i < BYTES_PER_WORD; i++) begin
            if (COUNT_W'(i) < count) begin
                c = crc_byte(c, data[8*i +: 8]);
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/crc32_stream_engine_core.sv =====
// A result reaches o_valid after its last word passes the input register, the queue
// and the output register. Throughput: one word of up to 8 bytes per cycle when not
// stalled, set by the combinational 8-byte XOR network that feeds the running CRC
// register back to itself. Reset (i_rst_n low, synchronous): running CRC loads all
// ones, the queue and the input and output stages empty.
module crc32_stream_engine_core
    import ccse_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [DATA_W-1:0]  i_data_word,
    input  logic [COUNT_W-1:0] i_byte_count,
    input  logic               i_first_word,
    input  logic               i_last_word,
    input  logic [CRC_W-1:0]   i_seed_crc,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [CRC_W-1:0]   o_crc_value
);

    logic  push;
    logic  full;
    logic  pop;
    logic  q_valid;
    t_item push_item;
    t_item q_item;

    ccse_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_data_word  (i_data_word),
        .i_byte_count (i_byte_count),
        .i_first_word (i_first_word),
        .i_last_word  (i_last_word),
        .i_seed_crc   (i_seed_crc),
        .o_push       (push),
        .o_item       (push_item),
        .i_full       (full)
    );

    ccse_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_full  (full),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_pop   (pop)
    );

    ccse_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_crc_value (o_crc_value)
    );

endmodule

// ===== rtl/core/ccse_front.sv =====
module ccse_front
    import ccse_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [DATA_W-1:0]  i_data_word,
    input  logic [COUNT_W-1:0] i_byte_count,
    input  logic               i_first_word,
    input  logic               i_last_word,
    input  logic [CRC_W-1:0]   i_seed_crc,
    output logic               o_push,
    output t_item              o_item,
    input  logic               i_full
);

    logic  r_valid;
    logic  n_valid;
    t_item r_item;
    t_item n_item;
    logic  accept;

    assign o_stall = r_valid && i_full;
    assign accept  = i_valid && !o_stall;
    assign o_push  = r_valid && !i_full;
    assign o_item  = r_item;

    always_comb begin
        n_item            = r_item;
        n_valid           = r_valid && i_full;
        if (accept) begin
            n_valid           = 1'b1;
            n_item.data_word  = i_data_word;
            n_item.byte_count = (i_byte_count > COUNT_W'(BYTES_PER_WORD))
                                ? COUNT_W'(BYTES_PER_WORD) : i_byte_count;
            n_item.first_word = i_first_word;
            n_item.last_word  = i_last_word;
            n_item.seed_crc   = i_seed_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_item <= n_item;
    end

endmodule

// ===== rtl/core/ccse_queue.sv =====
module ccse_queue
    import ccse_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    output logic  o_valid,
    output t_item o_item,
    input  logic  i_pop
);

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QPTR_W-1:0] n_wr_ptr;
    logic [QPTR_W-1:0] n_rd_ptr;
    logic [QCNT_W-1:0] n_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue fill count lost a push");

endmodule

// ===== rtl/core/ccse_back.sv =====
module ccse_back
    import ccse_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  t_item            i_q_item,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [CRC_W-1:0] o_crc_value
);

    logic [CRC_W-1:0] r_crc;
    logic [CRC_W-1:0] n_crc;
    logic             r_ovalid;
    logic             n_ovalid;
    logic [CRC_W-1:0] r_out;
    logic [CRC_W-1:0] n_out;
    logic [CRC_W-1:0] start_crc;
    logic [CRC_W-1:0] word_crc;
    logic             out_free;

    assign out_free    = !r_ovalid || !i_stall;
    assign o_pop       = i_q_valid && (!i_q_item.last_word || out_free);
    assign o_valid     = r_ovalid;
    assign o_crc_value = r_out;

    assign start_crc = i_q_item.first_word ? ~i_q_item.seed_crc : r_crc;
    assign word_crc  = crc_word(start_crc, i_q_item.data_word, i_q_item.byte_count);

    always_comb begin
        n_crc    = r_crc;
        n_out    = r_out;
        n_ovalid = r_ovalid && i_stall;
        if (o_pop) begin
            n_crc = word_crc;
            if (i_q_item.last_word) begin
                n_out    = ~word_crc;
                n_ovalid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc    <= CRC_INIT;
            r_ovalid <= 1'b0;
        end else begin
            r_crc    <= n_crc;
            r_ovalid <= n_ovalid;
        end
        r_out <= n_out;
    end

    a_last_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_q_item.last_word) |=> (r_ovalid && r_out == ~r_crc))
        else $error("last transfer did not produce a result");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && i_stall) |-> !(o_pop && i_q_item.last_word))
        else $error("pending result overwritten");

    a_crc_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_pop |=> (r_crc == $past(r_crc)))
        else $error("running crc changed without a transfer");

endmodule
